// File: rtl/bbc_pkg.sv
// ============================================================================
// bbc_pkg
// Shared types and constants for the bracket balance checker.
// ============================================================================
package bbc_pkg;

    localparam int KIND_W          = 4;
    localparam int STATUS_W        = 3;
    localparam int DEF_STACK_DEPTH = 32;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED   = 3'd0,
        ST_MATCHED  = 3'd1,
        ST_UNOPENED = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_UNCLOSED = 3'd4,
        ST_DONE     = 3'd5
    } t_status;

    // stack operation for one cycle, sent from control to the cell chain
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [KIND_W-1:0] kind;
    } t_stack_op;

endpackage

// File: rtl/bbc_cell.sv
// ============================================================================
// bbc_cell
// One stack entry. Shifts down (toward the bottom) on a push, up on a pop.
// ============================================================================
module bbc_cell (
    input  logic                      i_clk,
    input  bbc_pkg::t_stack_op        i_op,
    input  logic [bbc_pkg::KIND_W-1:0] i_from_above,
    input  logic [bbc_pkg::KIND_W-1:0] i_from_below,
    output logic [bbc_pkg::KIND_W-1:0] o_kind
);
    import bbc_pkg::*;

    logic [KIND_W-1:0] r_kind;
    logic [KIND_W-1:0] n_kind;

    // pick the neighbor value for the next cycle
    always_comb begin
        n_kind = r_kind;
        if (i_op.push) begin
            n_kind = i_from_above;
        end else if (i_op.pop) begin
            n_kind = i_from_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
    end

    assign o_kind = r_kind;

endmodule

// File: rtl/bbc_stack.sv
// ============================================================================
// bbc_stack
// Opener stack built as a chain of cells; cell 0 is the top of stack.
// Also keeps the fill count.
// ============================================================================
module bbc_stack #(
    parameter int STACK_DEPTH = bbc_pkg::DEF_STACK_DEPTH,
    parameter int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bbc_pkg::t_stack_op         i_op,
    output logic [bbc_pkg::KIND_W-1:0] o_top_kind,
    output logic [CNT_W-1:0]           o_count
);
    import bbc_pkg::*;

    logic [KIND_W-1:0] w_kind [STACK_DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    // chain of cells: each takes the value above on push, below on pop
    for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
        logic [KIND_W-1:0] w_above;
        logic [KIND_W-1:0] w_below;
        if (gi == 0) begin : g_top
            assign w_above = i_op.kind;
        end else begin : g_mid_top
            assign w_above = w_kind[gi-1];
        end
        if (gi == STACK_DEPTH - 1) begin : g_bot
            assign w_below = w_kind[gi];
        end else begin : g_mid_bot
            assign w_below = w_kind[gi+1];
        end
        bbc_cell u_cell (
            .i_clk        (i_clk),
            .i_op         (i_op),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_kind       (w_kind[gi])
        );
    end

    // fill count
    always_comb begin
        n_count = r_count;
        if (i_op.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_op.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_top_kind = w_kind[0];
    assign o_count    = r_count;

endmodule

// File: rtl/bracket_balance_checker.sv
// ============================================================================
// bracket_balance_checker
// Bracket balance check over a token stream with a cell-chain opener stack.
// ============================================================================
// A bracket token item gives one result, and tokens can be accepted on every
// cycle while results are taken. A flush item is taken first, then the cell
// chain pops one entry per cycle while results are taken, each reported as an
// unclosed opener from the top down, then a done result closes the flush. A
// stall on the result side holds the flush. No new item is accepted during a
// flush. Results wait in a single output register; a new token is accepted in
// the same cycle the held result is taken. The stack has no reset pass: only
// its count clears.
module bracket_balance_checker #(
    parameter int STACK_DEPTH = bbc_pkg::DEF_STACK_DEPTH,
    parameter int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // token channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_command,
    input  logic [bbc_pkg::KIND_W-1:0]   i_bracket_kind,
    input  logic                         i_is_closer,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [bbc_pkg::STATUS_W-1:0] o_status,
    output logic [bbc_pkg::KIND_W-1:0]   o_top_kind,
    output logic [CNT_W-1:0]             o_stack_depth,
    output logic                         o_overflow,
    output logic                         o_last
);
    import bbc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_FLUSH = 2'b10
    } t_state;

    t_state            r_state, n_state;
    logic              r_out_valid, n_out_valid;
    t_status           r_status, n_status;
    logic [KIND_W-1:0] r_top_kind, n_top_kind;
    logic [CNT_W-1:0]  r_depth, n_depth;
    logic              r_ovf, n_ovf;
    logic              r_last, n_last;

    t_stack_op         w_op;
    logic [KIND_W-1:0] w_top;
    logic [CNT_W-1:0]  w_count;
    logic              w_slot_free;
    logic              w_in_fire;
    logic              w_full;
    logic              w_empty;

    bbc_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .CNT_W       (CNT_W)
    ) u_stack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_op),
        .o_top_kind (w_top),
        .o_count    (w_count)
    );

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_slot_free;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_full      = (w_count == CNT_W'(STACK_DEPTH));
    assign w_empty     = (w_count == '0);

    // token handling, flush sequencing and the next result
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_top_kind  = r_top_kind;
        n_depth     = r_depth;
        n_ovf       = r_ovf;
        n_last      = r_last;
        w_op        = '{push: 1'b0, pop: 1'b0, kind: i_bracket_kind};

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (i_command) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_out_valid = 1'b1;
                        n_ovf       = 1'b0;
                        n_last      = 1'b1;
                        if (!i_is_closer) begin
                            // opener: push, or drop when full
                            n_status   = ST_PUSHED;
                            n_top_kind = i_bracket_kind;
                            if (w_full) begin
                                n_depth = w_count;
                                n_ovf   = 1'b1;
                            end else begin
                                w_op.push = 1'b1;
                                n_depth   = w_count + CNT_W'(1);
                            end
                        end else if (w_empty) begin
                            n_status   = ST_UNOPENED;
                            n_top_kind = '0;
                            n_depth    = '0;
                        end else if (w_top != i_bracket_kind) begin
                            n_status   = ST_MISMATCH;
                            n_top_kind = w_top;
                            n_depth    = w_count;
                        end else begin
                            w_op.pop   = 1'b1;
                            n_status   = ST_MATCHED;
                            n_top_kind = w_top;
                            n_depth    = w_count - CNT_W'(1);
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_ovf       = 1'b0;
                    if (!w_empty) begin
                        // report top opener and pop it
                        w_op.pop   = 1'b1;
                        n_status   = ST_UNCLOSED;
                        n_top_kind = w_top;
                        n_depth    = w_count - CNT_W'(1);
                        n_last     = 1'b0;
                    end else begin
                        n_status   = ST_DONE;
                        n_top_kind = '0;
                        n_depth    = '0;
                        n_last     = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_top_kind <= n_top_kind;
        r_depth    <= n_depth;
        r_ovf      <= n_ovf;
        r_last     <= n_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_top_kind    = r_top_kind;
    assign o_stack_depth = r_depth;
    assign o_overflow    = r_ovf;
    assign o_last        = r_last;

    // no new item while a flush drains
    a_flush_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> !o_in_ready)
        else $error("input accepted during flush");

    // count never passes the stack size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count above depth");

    // only flush reports are non-final
    a_nonlast_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_last) |-> (r_state == S_FLUSH && r_status == ST_UNCLOSED))
        else $error("non-final result outside flush");

    // overflow only on a push at full depth
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ovf) |->
            (r_status == ST_PUSHED && r_depth == CNT_W'(STACK_DEPTH)))
        else $error("overflow flag without full stack");

    // flush ends with an empty stack
    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_DONE) |-> (r_depth == '0 && w_empty))
        else $error("flush done with openers left");

endmodule
